### rtl/core/integer_block_sorter_macros.svh
// Assertion macros for the integer block sorter checker.
`ifndef INTEGER_BLOCK_SORTER_MACROS_SVH
`define INTEGER_BLOCK_SORTER_MACROS_SVH

// Clocked property with reset disable.
`define ISRT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never hold.
`define ISRT_NEVER(name, clk, rst_n, expr, msg) \
  `ISRT_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

### rtl/core/isrt_pkg.sv
// Types shared by the integer block sorter modules.
`timescale 1ns / 1ps
package isrt_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_block;
    logic               overflowed;
  } out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

### rtl/core/integer_block_sorter.sv
// Integer block sorter: a chain of insertion cells that unloads in ascending order.
// Each request is written to its sorted cell when accepted; a new request is taken every cycle while collecting.
// After a request marked last, the block emits count results from cell 0, one per cycle while out_ready is high,
// and takes no request until the final result is accepted.
// Reset (rst_n, synchronous, active low) empties the chain and clears the overflow flag.
`timescale 1ns / 1ps
module integer_block_sorter #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  isrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output isrt_pkg::out_t out_data
);
  import isrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               unload_r, unload_nxt;
  logic               in_acc, out_acc, full, fin;
  cell_ctl_t          ctl;
  logic signed [31:0] val_w [MAX_ELEMENTS];
  logic               gt_w  [MAX_ELEMENTS];

  assign in_ready  = !unload_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = unload_r;
  assign out_acc   = out_valid && out_ready;
  assign full      = count_r == CNT_W'(MAX_ELEMENTS);
  assign fin       = count_r == CNT_W'(1);

  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = out_acc;
  assign ctl.value  = in_data.value;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic signed [31:0] prev_val;
    logic               prev_gt;
    logic signed [31:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val = in_data.value;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val_w[i-1];
      assign prev_gt  = gt_w[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign next_val = val_w[i];
    end else begin : g_mid
      assign next_val = val_w[i+1];
    end

    isrt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .next_val (next_val),
      .val      (val_w[i]),
      .gt       (gt_w[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    unload_nxt = unload_r;
    if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      unload_nxt = in_data.last;
    end
    if (out_acc) begin
      count_nxt = count_r - CNT_W'(1);
      if (fin) begin
        unload_nxt = 1'b0;
        ovf_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      unload_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      unload_r <= unload_nxt;
    end
  end

  assign out_data.sorted_value = val_w[0];
  assign out_data.end_of_block = fin;
  assign out_data.overflowed   = fin && ovf_r;

endmodule

### rtl/core/isrt_cell.sv
// One insertion cell of the sorting chain.
`timescale 1ns / 1ps
module isrt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  isrt_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]    count,
  input  logic signed [31:0]  prev_val,
  input  logic                prev_gt,
  input  logic signed [31:0]  next_val,
  output logic signed [31:0]  val,
  output logic                gt
);
  import isrt_pkg::*;

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               occ;
  logic               is_slot;

  assign occ     = CNT_W'(IDX) < count;
  assign is_slot = CNT_W'(IDX) == count;
  // Equal values stay ahead of the newcomer, so only a strictly greater one moves.
  assign gt      = occ && (val_r > ctl.value);

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.insert && (gt || is_slot)) begin
      val_nxt = prev_gt ? prev_val : ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### rtl/core/isrt_checker.sv
// Port-level checker for the integer block sorter, bound to the top level.
`timescale 1ns / 1ps
`include "integer_block_sorter_macros.svh"
module isrt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input isrt_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input isrt_pkg::out_t out_data
);
  import isrt_pkg::*;

  // Collection and unloading never overlap.
  `ISRT_NEVER(a_no_overlap, clk, rst_n, out_valid && in_ready, "request taken during unload")

  // The overflow flag only rides on the final result.
  `ISRT_NEVER(a_ovf_on_end, clk, rst_n, out_valid && out_data.overflowed && !out_data.end_of_block, "overflow flag before end of block")

  // Once the final result is taken, the block collects again.
  `ISRT_ASSERT(a_end_frees, clk, rst_n, out_valid && out_ready && out_data.end_of_block |=> in_ready && !out_valid, "block did not return to collecting")

  // A last request starts the unload in the next cycle.
  `ISRT_ASSERT(a_last_unloads, clk, rst_n, in_valid && in_ready && in_data.last |=> out_valid, "no results after last request")

  // A stalled result holds.
  `ISRT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind integer_block_sorter isrt_checker u_isrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
